@@ rtl/pnpf_pkg.sv @@
// Shared constants, types and item layout for the periodic neighbor pair filter.
// No dependencies; every other file of the block imports this package.
package pnpf_pkg;

    // Datapath sizing
    localparam int INDEX_BITS = 24;
    localparam int COORD_BITS = 32;

    // Fixed field widths
    localparam int BOX_W     = 30;
    localparam int LIMIT_W   = 60;
    localparam int BAND_W    = 10;
    localparam int BOND_W    = 3;
    localparam int IMAGE_W   = 5;
    localparam int OWNER_W   = 24;
    localparam int ENTRY_W   = 32;
    localparam int ENTRY_IDX_W = 24;
    localparam int NUM_AXES  = 3;

    // Pipeline: stages 1..6, the last one is the output register
    localparam int NUM_STAGES = 6;

    // Displacement arithmetic
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int FOLD_W = ((DIFF_W > BOX_W) ? DIFF_W : BOX_W) + 2;
    localparam int MAG_W  = 31;                  // magnitudes at or above 2^31 saturate
    localparam int PROD_W = 2 * MAG_W;
    localparam int SQ_W   = PROD_W + 1;          // room for the saturation value 2^62
    localparam int SUM_W  = SQ_W + 1;
    localparam logic [SQ_W-1:0] SQ_CAP = SQ_W'(1) << PROD_W;

    localparam int GAP_W = (INDEX_BITS > BAND_W) ? INDEX_BITS : BAND_W;

    // Image code: start in the middle cell, step 9/3/1 per axis
    localparam logic [IMAGE_W-1:0] IMG_BASE = IMAGE_W'(13);
    localparam logic [NUM_AXES-1:0][IMAGE_W-1:0] IMG_STEP =
        {IMAGE_W'(1), IMAGE_W'(3), IMAGE_W'(9)};
    localparam logic [BOND_W-1:0] BOND_OUTSIDE = BOND_W'(7);

    // Input item layout in s_tdata (lowest field first)
    localparam int OFF_OWNER   = 0;
    localparam int OFF_PARTNER = OFF_OWNER + INDEX_BITS;
    localparam int OFF_OWN_X   = OFF_PARTNER + INDEX_BITS;
    localparam int OFF_PART_X  = OFF_OWN_X + NUM_AXES * COORD_BITS;
    localparam int OFF_BOND    = OFF_PART_X + NUM_AXES * COORD_BITS;
    localparam int IN_BITS     = OFF_BOND + BOND_W;
    localparam int S_TDATA_W   = ((IN_BITS + 7) / 8) * 8;

    localparam int OUT_BITS    = OWNER_W + ENTRY_W;
    localparam int M_TDATA_W   = ((OUT_BITS + 7) / 8) * 8;

    // Configuration port
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 6;
    localparam int REG_IDX_W  = 3;
    localparam int REG_LSB    = 3;               // registers every 8 bytes

    localparam logic [BOX_W-1:0] BOX_RESET = {BOX_W{1'b1}};

    typedef enum logic [REG_IDX_W-1:0] {
        REG_PERIODIC = 3'd0,
        REG_BOX_X    = 3'd1,
        REG_BOX_Y    = 3'd2,
        REG_BOX_Z    = 3'd3,
        REG_LIMIT    = 3'd4,
        REG_BAND     = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic                             periodic_mode;
        logic [NUM_AXES-1:0][BOX_W-1:0]   box_len;
        logic [LIMIT_W-1:0]               limit_dist_sq;
        logic [BAND_W-1:0]                band_width;
    } cfg_t;

    // Per-stage load enables, bit k loads stage k+1
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } pipe_ctl_t;

endpackage

@@ rtl/pnpf_cfg.sv @@
// Configuration register file behind the APB-style port.
// Depends on pnpf_pkg.
module pnpf_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pnpf_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [pnpf_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [pnpf_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    output pnpf_pkg::cfg_t                     cfg
);
    import pnpf_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    cfg_reg_t reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = cfg_reg_t'(paddr[REG_LSB +: REG_IDX_W]);

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_PERIODIC: cfg_next.periodic_mode = pwdata[0];
                REG_BOX_X:    cfg_next.box_len[0]    = pwdata[BOX_W-1:0];
                REG_BOX_Y:    cfg_next.box_len[1]    = pwdata[BOX_W-1:0];
                REG_BOX_Z:    cfg_next.box_len[2]    = pwdata[BOX_W-1:0];
                REG_LIMIT:    cfg_next.limit_dist_sq = pwdata[LIMIT_W-1:0];
                REG_BAND:     cfg_next.band_width    = pwdata[BAND_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_PERIODIC: prdata = APB_DATA_W'(cfg_reg.periodic_mode);
            REG_BOX_X:    prdata = APB_DATA_W'(cfg_reg.box_len[0]);
            REG_BOX_Y:    prdata = APB_DATA_W'(cfg_reg.box_len[1]);
            REG_BOX_Z:    prdata = APB_DATA_W'(cfg_reg.box_len[2]);
            REG_LIMIT:    prdata = APB_DATA_W'(cfg_reg.limit_dist_sq);
            REG_BAND:     prdata = APB_DATA_W'(cfg_reg.band_width);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.periodic_mode <= 1'b1;
            cfg_reg.box_len       <= {NUM_AXES{BOX_RESET}};
            cfg_reg.limit_dist_sq <= '0;
            cfg_reg.band_width    <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/pnpf_axis.sv @@
// One axis lane: displacement, minimum-image fold, magnitude, saturating square.
// Four register stages driven by the shared load enables; depends on pnpf_pkg.
module pnpf_axis (
    input  logic                                  aclk,
    input  pnpf_pkg::pipe_ctl_t                   ctl,
    input  logic                                  periodic_mode,
    input  logic [pnpf_pkg::BOX_W-1:0]            box_len,
    input  logic signed [pnpf_pkg::COORD_BITS-1:0] owner_pos,
    input  logic signed [pnpf_pkg::COORD_BITS-1:0] partner_pos,
    output logic [pnpf_pkg::SQ_W-1:0]             sq_term,
    output logic                                  img_up,
    output logic                                  img_dn
);
    import pnpf_pkg::*;

    // stage 1
    logic signed [DIFF_W-1:0] d1_reg;
    logic signed [DIFF_W-1:0] d1_next;
    // stage 2
    logic signed [FOLD_W-1:0] d2_reg, d2_next;
    logic                     up2_reg, up2_next, dn2_reg, dn2_next;
    logic signed [FOLD_W-1:0] d_ext, twice, box_s;
    // stage 3
    logic [MAG_W-1:0]         mag3_reg, mag3_next;
    logic                     sat3_reg, sat3_next;
    logic                     up3_reg, dn3_reg;
    logic [FOLD_W-1:0]        abs_val;
    // stage 4
    logic [SQ_W-1:0]          sq4_reg, sq4_next;
    logic                     up4_reg, dn4_reg;
    logic [PROD_W-1:0]        prod;

    assign d1_next = DIFF_W'(partner_pos) - DIFF_W'(owner_pos);

    // Fold once: 2d beyond +box or -box moves by one box length
    always_comb begin
        d_ext   = FOLD_W'(d1_reg);
        twice   = d_ext <<< 1;
        box_s   = $signed(FOLD_W'({1'b0, box_len}));
        d2_next = d_ext;
        up2_next = 1'b0;
        dn2_next = 1'b0;
        if (periodic_mode) begin
            if (twice > box_s) begin
                d2_next  = d_ext - box_s;
                dn2_next = 1'b1;
            end else if (twice < -box_s) begin
                d2_next  = d_ext + box_s;
                up2_next = 1'b1;
            end
        end
    end

    always_comb begin
        abs_val   = d2_reg[FOLD_W-1] ? FOLD_W'(-d2_reg) : FOLD_W'(d2_reg);
        sat3_next = |abs_val[FOLD_W-1:MAG_W];
        mag3_next = abs_val[MAG_W-1:0];
    end

    assign prod     = mag3_reg * mag3_reg;
    assign sq4_next = sat3_reg ? SQ_CAP : SQ_W'(prod);

    always_ff @(posedge aclk) begin
        if (ctl.load[0]) begin
            d1_reg <= d1_next;
        end
        if (ctl.load[1]) begin
            d2_reg  <= d2_next;
            up2_reg <= up2_next;
            dn2_reg <= dn2_next;
        end
        if (ctl.load[2]) begin
            mag3_reg <= mag3_next;
            sat3_reg <= sat3_next;
            up3_reg  <= up2_reg;
            dn3_reg  <= dn2_reg;
        end
        if (ctl.load[3]) begin
            sq4_reg <= sq4_next;
            up4_reg <= up3_reg;
            dn4_reg <= dn3_reg;
        end
    end

    assign sq_term = sq4_reg;
    assign img_up  = up4_reg;
    assign img_dn  = dn4_reg;

endmodule

@@ rtl/pnpf_index.sv @@
// Index side path: index gap, band check, bond order and self-pair drop,
// carried through five stages to line up with the axis lanes. Depends on pnpf_pkg.
module pnpf_index (
    input  logic                                aclk,
    input  pnpf_pkg::pipe_ctl_t                 ctl,
    input  logic [pnpf_pkg::BAND_W-1:0]         band_width,
    input  logic [pnpf_pkg::INDEX_BITS-1:0]     owner_index,
    input  logic [pnpf_pkg::INDEX_BITS-1:0]     partner_index,
    input  logic [pnpf_pkg::BOND_W-1:0]         band_bond_order,
    output logic [pnpf_pkg::INDEX_BITS-1:0]     owner_out,
    output logic [pnpf_pkg::INDEX_BITS-1:0]     partner_out,
    output logic [pnpf_pkg::BOND_W-1:0]         bond_out,
    output logic                                drop_out
);
    import pnpf_pkg::*;

    localparam int CARRY = 3;     // stages 3..5 only carry the item

    logic [INDEX_BITS-1:0] own1_reg, part1_reg, gap1_reg, gap1_next;
    logic [BOND_W-1:0]     bbo1_reg;

    logic [CARRY:0][INDEX_BITS-1:0] own_reg, part_reg;
    logic [CARRY:0][BOND_W-1:0]     bond_reg;
    logic [CARRY:0]                 drop_reg;
    logic                           in_band;
    logic [BOND_W-1:0]              bond2_next;
    logic                           drop2_next;

    assign gap1_next = (partner_index > owner_index) ? partner_index - owner_index
                                                     : owner_index - partner_index;

    always_comb begin
        in_band    = GAP_W'(gap1_reg) < GAP_W'(band_width);
        bond2_next = in_band ? bbo1_reg : BOND_OUTSIDE;
        drop2_next = in_band && (gap1_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[0]) begin
            own1_reg  <= owner_index;
            part1_reg <= partner_index;
            gap1_reg  <= gap1_next;
            bbo1_reg  <= band_bond_order;
        end
        if (ctl.load[1]) begin
            own_reg[0]  <= own1_reg;
            part_reg[0] <= part1_reg;
            bond_reg[0] <= bond2_next;
            drop_reg[0] <= drop2_next;
        end
        for (int k = 1; k <= CARRY; k++) begin
            if (ctl.load[k+1]) begin
                own_reg[k]  <= own_reg[k-1];
                part_reg[k] <= part_reg[k-1];
                bond_reg[k] <= bond_reg[k-1];
                drop_reg[k] <= drop_reg[k-1];
            end
        end
    end

    assign owner_out   = own_reg[CARRY];
    assign partner_out = part_reg[CARRY];
    assign bond_out    = bond_reg[CARRY];
    assign drop_out    = drop_reg[CARRY];

endmodule

@@ rtl/periodic_neighbor_pair_filter.sv @@
// One item per cycle sustained while the receiver keeps m_tready high.
// Throughput is set by the six-stage pipeline (subtract, fold, magnitude, square,
// sum, compare/pack), each stage loading whenever it is empty or its successor loads.
// Reset (aresetn low, synchronous) clears all valid bits and restores the registers:
// periodic_mode 1, box lengths all ones, limit_dist_sq 0, band_width 0.
// Depends on pnpf_pkg, pnpf_cfg, pnpf_axis, pnpf_index.
module periodic_neighbor_pair_filter (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input items
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // owner_index, partner_index, owner_x, owner_y, owner_z,
    // partner_x, partner_y, partner_z, band_bond_order, zero pad
    input  logic [pnpf_pkg::S_TDATA_W-1:0]     s_tdata,
    // result items
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // list_owner, neighbor_entry
    output logic [pnpf_pkg::M_TDATA_W-1:0]     m_tdata,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pnpf_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [pnpf_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [pnpf_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import pnpf_pkg::*;

    cfg_t      cfg;
    pipe_ctl_t ctl;

    logic [NUM_STAGES-1:0] valid_reg, valid_next;
    logic [NUM_STAGES-1:0] load;

    logic [NUM_AXES-1:0][SQ_W-1:0] sq_term;
    logic [NUM_AXES-1:0]           img_up, img_dn;

    logic [INDEX_BITS-1:0] owner5, partner5;
    logic [BOND_W-1:0]     bond5;
    logic                  drop5;

    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [IMAGE_W-1:0] image_reg, image_next;

    logic [OWNER_W-1:0] out_owner_reg, out_owner_next;
    logic [ENTRY_W-1:0] out_entry_reg, out_entry_next;
    logic               pass;

    pnpf_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Elastic pipeline control: a stage loads when it is empty or the one after
    // it loads, so bubbles close up while the output waits.
    always_comb begin
        load[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            load[k] = !valid_reg[k] || load[k+1];
        end
    end

    assign ctl.load = load;
    assign s_tready = load[0];

    genvar a;
    generate
        for (a = 0; a < NUM_AXES; a++) begin : g_axis
            pnpf_axis u_axis (
                .aclk          (aclk),
                .ctl           (ctl),
                .periodic_mode (cfg.periodic_mode),
                .box_len       (cfg.box_len[a]),
                .owner_pos     (s_tdata[OFF_OWN_X  + a*COORD_BITS +: COORD_BITS]),
                .partner_pos   (s_tdata[OFF_PART_X + a*COORD_BITS +: COORD_BITS]),
                .sq_term       (sq_term[a]),
                .img_up        (img_up[a]),
                .img_dn        (img_dn[a])
            );
        end
    endgenerate

    pnpf_index u_index (
        .aclk            (aclk),
        .ctl             (ctl),
        .band_width      (cfg.band_width),
        .owner_index     (s_tdata[OFF_OWNER   +: INDEX_BITS]),
        .partner_index   (s_tdata[OFF_PARTNER +: INDEX_BITS]),
        .band_bond_order (s_tdata[OFF_BOND    +: BOND_W]),
        .owner_out       (owner5),
        .partner_out     (partner5),
        .bond_out        (bond5),
        .drop_out        (drop5)
    );

    // Stage 5: add the three squared terms and settle the image code.
    // A saturated term is 2^62, so three of them still fit the sum.
    always_comb begin
        sum_next   = SUM_W'(sq_term[0]) + SUM_W'(sq_term[1]) + SUM_W'(sq_term[2]);
        image_next = IMG_BASE;
        for (int k = 0; k < NUM_AXES; k++) begin
            if (img_up[k]) begin
                image_next = image_next + IMG_STEP[k];
            end
            if (img_dn[k]) begin
                image_next = image_next - IMG_STEP[k];
            end
        end
        if (!cfg.periodic_mode) begin
            image_next = '0;
        end
    end

    // Stage 6: compare against the limit, drop the self pair, pack the entry
    always_comb begin
        pass           = (sum_reg <= SUM_W'(cfg.limit_dist_sq)) && !drop5;
        out_owner_next = OWNER_W'(owner5);
        out_entry_next = {image_reg, bond5, ENTRY_IDX_W'(partner5)};
    end

    always_comb begin
        valid_next = valid_reg;
        if (load[0]) begin
            valid_next[0] = s_tvalid;
        end
        for (int k = 1; k < NUM_STAGES - 1; k++) begin
            if (load[k]) begin
                valid_next[k] = valid_reg[k-1];
            end
        end
        if (load[NUM_STAGES-1]) begin
            valid_next[NUM_STAGES-1] = valid_reg[NUM_STAGES-2] && pass;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load[4]) begin
            sum_reg   <= sum_next;
            image_reg <= image_next;
        end
        if (load[5]) begin
            out_owner_reg <= out_owner_next;
            out_entry_reg <= out_entry_next;
        end
    end

    assign m_tvalid = valid_reg[NUM_STAGES-1];
    assign m_tdata  = M_TDATA_W'({out_entry_reg, out_owner_reg});

endmodule

@@ rtl/pnpf_checker.sv @@
// Port-level checks for the periodic neighbor pair filter, bound to the top level.
// Depends on pnpf_pkg.
module pnpf_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [pnpf_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                               psel,
    input  logic                               pready
);
    import pnpf_pkg::*;

    localparam int IMG_LSB = OWNER_W + ENTRY_IDX_W + BOND_W;
    localparam logic [IMAGE_W-1:0] IMG_MAX = IMAGE_W'(26);

    // A waiting result item holds until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed or vanished while stalled");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result item shown right after reset");

    // With no result pending every stage can move, so input is taken
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid && s_tvalid |-> s_tready)
        else $error("input stalled with an empty output");

    // Image code never leaves the 3x3x3 range
    a_image_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[IMG_LSB +: IMAGE_W] <= IMG_MAX)
        else $error("image code out of range");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        psel |-> pready)
        else $error("configuration port not ready");

endmodule

bind periodic_neighbor_pair_filter pnpf_checker u_pnpf_checker (.*);

@@ tb/pnpf_tb_pkg.sv @@
// Item type and scoreboard for the periodic neighbor pair filter testbench.
// Depends on pnpf_pkg for widths, register codes and the image constants.
package pnpf_tb_pkg;
    import pnpf_pkg::*;

    typedef struct {
        logic [INDEX_BITS-1:0]        owner_index;
        logic [INDEX_BITS-1:0]        partner_index;
        logic signed [COORD_BITS-1:0] owner_pos [NUM_AXES];
        logic signed [COORD_BITS-1:0] partner_pos [NUM_AXES];
        logic [BOND_W-1:0]            bond;
    } pair_t;

    typedef struct {
        logic [OWNER_W-1:0] list_owner;
        logic [ENTRY_W-1:0] neighbor_entry;
    } nbr_entry_t;

    class neighbor_scoreboard;
        bit              periodic;
        longint unsigned box_len [NUM_AXES];
        longint unsigned limit_sq;
        int unsigned     band;
        nbr_entry_t      expected_q [$];
        int              failures;

        function new();
            periodic = 1'b1;
            foreach (box_len[a]) box_len[a] = BOX_RESET;
            limit_sq = 0;
            band     = 0;
            failures = 0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [APB_DATA_W-1:0] value);
            case (idx)
                REG_PERIODIC: periodic = value[0];
                REG_BOX_X:    box_len[0] = value[BOX_W-1:0];
                REG_BOX_Y:    box_len[1] = value[BOX_W-1:0];
                REG_BOX_Z:    box_len[2] = value[BOX_W-1:0];
                REG_LIMIT:    limit_sq = value[LIMIT_W-1:0];
                REG_BAND:     band = value[BAND_W-1:0];
                default: ;
            endcase
        endfunction

        // Fold each axis once, square with saturation, then filter on distance and band.
        function void note_pair(pair_t p);
            longint          d;
            longint          b;
            longint unsigned mag;
            longint unsigned sum;
            longint unsigned gap;
            int              image;
            int              step;
            logic [BOND_W-1:0] bond;
            nbr_entry_t      e;
            image = IMG_BASE;
            sum   = 0;
            for (int a = 0; a < NUM_AXES; a++) begin
                d    = longint'(p.partner_pos[a]) - longint'(p.owner_pos[a]);
                step = IMG_STEP[a];
                if (periodic) begin
                    b = longint'(box_len[a]);
                    if (2 * d > b) begin
                        d     = d - b;
                        image = image - step;
                    end else if (2 * d < -b) begin
                        d     = d + b;
                        image = image + step;
                    end
                end
                mag = (d < 0) ? -d : d;
                sum += (mag >= (64'd1 << 31)) ? (64'd1 << 62) : mag * mag;
            end
            if (sum > limit_sq) return;
            gap = (p.partner_index > p.owner_index) ? p.partner_index - p.owner_index
                                                    : p.owner_index - p.partner_index;
            bond = BOND_OUTSIDE;
            if (gap < band) begin
                if (gap == 0) return;
                bond = p.bond;
            end
            e.list_owner     = p.owner_index;
            e.neighbor_entry = {periodic ? IMAGE_W'(image) : IMAGE_W'(0), bond,
                                ENTRY_IDX_W'(p.partner_index)};
            expected_q.push_back(e);
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] data);
            nbr_entry_t e;
            logic [OWNER_W-1:0] got_owner;
            logic [ENTRY_W-1:0] got_entry;
            got_owner = data[OWNER_W-1:0];
            got_entry = data[OWNER_W +: ENTRY_W];
            if (expected_q.size() == 0) begin
                $error("unexpected result: list_owner %h neighbor_entry %h",
                       got_owner, got_entry);
                failures++;
                return;
            end
            e = expected_q.pop_front();
            if (got_owner !== e.list_owner) begin
                $error("list_owner: expected %h, got %h", e.list_owner, got_owner);
                failures++;
            end
            if (got_entry !== e.neighbor_entry) begin
                $error("neighbor_entry: expected %h, got %h", e.neighbor_entry, got_entry);
                failures++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

endpackage

@@ tb/periodic_neighbor_pair_filter_tb.sv @@
// Testbench for periodic_neighbor_pair_filter: directed and random candidate pairs,
// checked against a minimum-image predictor over several register settings.
// Depends on pnpf_pkg and pnpf_tb_pkg (scoreboard and item type).
module periodic_neighbor_pair_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pnpf_pkg::*;
    import pnpf_tb_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = NUM_STAGES + 4;
    localparam int SEG_ITEMS    = 158;

    // One register setting plus the displacement spread used to build pairs for it
    typedef struct {
        bit              periodic;
        longint unsigned box_len [NUM_AXES];
        longint unsigned limit_sq;
        int unsigned     band;
        int unsigned     spread;
    } setting_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr    = '0;
    logic [APB_DATA_W-1:0]  pwdata   = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    int send_idle_pct = 9;
    int recv_idle_pct = 49;

    neighbor_scoreboard sb = new();

    periodic_neighbor_pair_filter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        // owner_index, partner_index, owner_x, owner_y, owner_z,
        // partner_x, partner_y, partner_z, band_bond_order, zero pad
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        // list_owner, neighbor_entry
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Receiver: pick the stall for the next cycle on the falling edge.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Check every result item taken at a rising edge.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata);
        end
    end

    // Watchdog: declare a failure and end the run once CYCLE_LIMIT is reached.
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("periodic_neighbor_pair_filter_tb: FAIL");
        $finish;
    end

    function automatic logic [S_TDATA_W-1:0] pack_pair(pair_t p);
        return S_TDATA_W'({p.bond,
                           p.partner_pos[2], p.partner_pos[1], p.partner_pos[0],
                           p.owner_pos[2], p.owner_pos[1], p.owner_pos[0],
                           p.partner_index, p.owner_index});
    endfunction

    function automatic pair_t make_pair(int unsigned owner, int unsigned partner,
                                        int ox, int oy, int oz, int px, int py, int pz,
                                        int unsigned bond);
        pair_t p;
        p.owner_index    = INDEX_BITS'(owner);
        p.partner_index  = INDEX_BITS'(partner);
        p.owner_pos[0]   = ox;
        p.owner_pos[1]   = oy;
        p.owner_pos[2]   = oz;
        p.partner_pos[0] = px;
        p.partner_pos[1] = py;
        p.partner_pos[2] = pz;
        p.bond           = BOND_W'(bond);
        return p;
    endfunction

    // Build a pair near its owner under the current setting; a share is pure noise.
    function automatic pair_t random_pair(int unsigned spread);
        pair_t  p;
        longint pos;
        longint off;
        longint q;
        longint b;
        int     delta;
        p.bond = BOND_W'($urandom);
        if ($urandom_range(99) < 15) begin
            p.owner_index   = INDEX_BITS'($urandom);
            p.partner_index = INDEX_BITS'($urandom);
            for (int a = 0; a < NUM_AXES; a++) begin
                p.owner_pos[a]   = $urandom;
                p.partner_pos[a] = $urandom;
            end
            return p;
        end
        p.owner_index = INDEX_BITS'($urandom);
        if ($urandom_range(9) == 0) begin
            p.partner_index = INDEX_BITS'($urandom);
        end else begin
            // stay around the band edge so both bond order sources show up
            delta = int'($urandom_range(2 * sb.band + 8)) - int'(sb.band + 4);
            p.partner_index = INDEX_BITS'(longint'(p.owner_index) + delta);
        end
        for (int a = 0; a < NUM_AXES; a++) begin
            b   = longint'(sb.box_len[a]);
            off = longint'($urandom_range(32'(2 * spread))) - spread;
            if (sb.periodic && b > 0) begin
                pos = longint'($urandom_range(32'(b - 1)));
                q   = pos + off;
                // wrap the partner back into the box so folding has work to do
                if (q < 0) q += b;
                else if (q >= b) q -= b;
            end else begin
                pos = longint'($urandom_range(32'h8000_0000)) - (64'sd1 <<< 30);
                q   = pos + off;
            end
            p.owner_pos[a]   = COORD_BITS'(pos);
            p.partner_pos[a] = COORD_BITS'(q);
        end
        return p;
    endfunction

    // Offer one item, with random gaps first, and hold it until taken.
    task automatic send_item(pair_t p);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= pack_pair(p);
        forever begin
            @(posedge aclk);
            if (s_tready) break;
        end
        sb.note_pair(p);
    endtask

    task automatic apb_write(cfg_reg_t idx, logic [APB_DATA_W-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(idx) << REG_LSB;
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        forever begin
            @(posedge aclk);
            if (pready) break;
        end
        sb.write_reg(idx, value);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Drop valid, wait for every expected item and for dropped pairs still in flight.
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apply_setting(setting_t c);
        drain();
        apb_write(REG_PERIODIC, APB_DATA_W'(c.periodic));
        apb_write(REG_BOX_X, APB_DATA_W'(c.box_len[0]));
        apb_write(REG_BOX_Y, APB_DATA_W'(c.box_len[1]));
        apb_write(REG_BOX_Z, APB_DATA_W'(c.box_len[2]));
        apb_write(REG_LIMIT, APB_DATA_W'(c.limit_sq));
        apb_write(REG_BAND, APB_DATA_W'(c.band));
    endtask

    // Settings for the random segments: ordinary boxes, tiny boxes, full-size boxes,
    // infinite space, the widest band and the largest limit.
    function automatic setting_t random_setting(int seg);
        setting_t c;
        case (seg)
            0: c = '{1'b1, '{40960, 36864, 49152}, 64'd205520896, 8, 17000};
            1: c = '{1'b1, '{5000, 3000, 7000}, 64'd6250000, 1023, 3000};
            2: c = '{1'b0, '{40960, 40960, 40960}, 64'd67108864, 3, 10000};
            3: c = '{1'b1, '{BOX_RESET, BOX_RESET, BOX_RESET}, 64'd1 << 58, 64, 1 << 29};
            4: c = '{1'b1, '{1, 2, 3}, 64'd4, 0, 2};
            default: c = '{1'b0, '{1000, 2000, 3000}, {LIMIT_W{1'b1}}, 1, 1 << 29};
        endcase
        return c;
    endfunction

    initial begin : stimulus
        setting_t c;
        int       big_neg;
        int       big_pos;
        big_neg = 32'sh8000_0000;
        big_pos = 32'sh7FFF_FFFF;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset setting: limit zero passes only coincident atoms, band zero lets
        // the self pair through.
        send_item(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 3));
        send_item(make_pair(24'hFFFFFF, 0, 77, -5, 9, 77, -5, 9, 1));
        send_item(make_pair(10, 11, 0, 0, 0, 1, 0, 0, 2));

        // Periodic box of 10.0 on each axis: fold boundaries, far images, band edges.
        c = '{1'b1, '{40960, 40960, 40960}, 64'd1 << 32, 16, 0};
        apply_setting(c);
        send_item(make_pair(100, 300, 0, 0, 0, 20480, 0, 0, 1));       // exactly half box
        send_item(make_pair(100, 300, 0, 0, 0, 20481, 0, 0, 1));       // fold x down
        send_item(make_pair(100, 300, 20481, 0, 0, 0, 0, 0, 1));       // fold x up
        send_item(make_pair(100, 300, 0, 0, 0, 0, 30000, 0, 1));       // fold y down
        send_item(make_pair(100, 300, 0, 0, 30000, 0, 0, 0, 1));       // fold z up
        send_item(make_pair(100, 300, 0, 0, 0, 25000, 25000, 25000, 1));
        send_item(make_pair(100, 300, 25000, 25000, 25000, 0, 0, 0, 1));
        send_item(make_pair(100, 300, 0, 0, 0, 100000, 0, 0, 1));      // outside the box
        send_item(make_pair(5, 6, big_neg, 0, 0, big_pos, 0, 0, 4));   // saturated square
        send_item(make_pair(5, 6, big_pos, big_pos, big_pos, big_neg, big_neg, big_neg, 4));
        send_item(make_pair(500, 500, 7, 7, 7, 7, 7, 7, 5));           // self pair in band
        send_item(make_pair(500, 515, 7, 7, 7, 8, 7, 7, 5));           // just inside band
        send_item(make_pair(500, 516, 7, 7, 7, 8, 7, 7, 5));           // on band edge
        send_item(make_pair(500, 499, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_pair(499, 500, 0, 0, 0, 0, 0, 0, 7));
        send_item(make_pair(0, 24'hFFFFFF, 0, 0, 0, 0, 0, 0, 6));

        // Infinite space with the largest limit and the widest band.
        c = '{1'b0, '{40960, 40960, 40960}, {LIMIT_W{1'b1}}, 1023, 0};
        apply_setting(c);
        send_item(make_pair(42, 42, 1, 2, 3, 1, 2, 3, 2));             // self pair in band
        send_item(make_pair(42, 1065, 0, 0, 0, 30000, -30000, 30000, 2));
        send_item(make_pair(42, 43, 0, 0, 0, big_pos, 0, 0, 2));       // just below saturation
        send_item(make_pair(42, 43, big_neg, 0, 0, big_pos, 0, 0, 2));

        // Zero and one-unit box lengths: the image still moves on every correction.
        c = '{1'b1, '{0, 1, 1}, {LIMIT_W{1'b1}}, 0, 0};
        apply_setting(c);
        send_item(make_pair(9, 9, 0, 0, 0, 5, 0, 0, 0));
        send_item(make_pair(9, 8, 0, 1, 0, 0, 0, 1, 0));
        send_item(make_pair(9, 8, 0, 0, 0, 0, 0, 0, 0));

        // Random segments: sender light and receiver heavy, then the reverse, then
        // both running flat out.
        for (int seg = 0; seg < 6; seg++) begin
            c = random_setting(seg);
            apply_setting(c);
            case (seg / 2)
                0: begin
                    send_idle_pct = 9;
                    recv_idle_pct = 49;
                end
                1: begin
                    send_idle_pct = 49;
                    recv_idle_pct = 9;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            repeat (SEG_ITEMS) send_item(random_pair(c.spread));
        end

        drain();
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("periodic_neighbor_pair_filter_tb: PASS");
        end else begin
            $display("periodic_neighbor_pair_filter_tb: FAIL");
        end
        $finish;
    end

endmodule
